// ===== rtl/api_frame_byte_parser_defines.svh =====
// Assertion macros shared by the frame parser RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef API_FRAME_BYTE_PARSER_DEFINES_SVH
`define API_FRAME_BYTE_PARSER_DEFINES_SVH
`ifndef SYNTHESIS
`define AFBP_ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);
`define AFBP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define AFBP_ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg)
`define AFBP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

// ===== rtl/afbp_pkg.sv =====
// Shared types and constants of the API frame byte parser.
// Depends on nothing; used by afbp_core and api_frame_byte_parser.
package afbp_pkg;

    localparam int MAX_DATA_DEFAULT = 256;

    localparam logic [7:0]  START_BYTE = 8'h7E;
    localparam logic [15:0] MIN_LENGTH = 16'd2;
    localparam logic [7:0]  GOOD_SUM   = 8'hFF;

    typedef enum logic [1:0] {
        ST_IDLE    = 2'd0,
        ST_PARSING = 2'd1,
        ST_GOOD    = 2'd2,
        ST_FAIL    = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_TYPE = 2'd1,
        KIND_DATA = 2'd2
    } kind_t;

    typedef struct packed {
        status_t     status;
        kind_t       kind;
        logic [7:0]  payload;
        logic [7:0]  data_index;
        logic        last_data;
        logic [15:0] frame_length;
    } result_t;

endpackage

// ===== rtl/afbp_core.sv =====
// Frame layout state machine and running checksum of the API frame parser.
// Depends on afbp_pkg and api_frame_byte_parser_defines.svh.
`include "api_frame_byte_parser_defines.svh"
module afbp_core #(
    parameter int MAX_DATA = afbp_pkg::MAX_DATA_DEFAULT
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step,
    input  logic [7:0]        rx_byte,
    output afbp_pkg::result_t res
);
    import afbp_pkg::*;

    localparam int CNT_W = $clog2(MAX_DATA + 1);
    localparam logic [16:0] MAX_LENGTH = 17'(MAX_DATA + 1);

    typedef enum logic [2:0] {
        PH_HUNT   = 3'd0,
        PH_LEN_HI = 3'd1,
        PH_LEN_LO = 3'd2,
        PH_TYPE   = 3'd3,
        PH_DATA   = 3'd4,
        PH_CHECK  = 3'd5
    } phase_t;

    phase_t             phase_reg, phase_next;
    logic [15:0]        length_reg, length_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [7:0]         sum_reg, sum_next;

    logic [15:0]        length_new;
    logic [CNT_W-1:0]   count_inc;
    logic [15:0]        count_ext;
    logic [7:0]         sum_add;

    assign length_new = {length_reg[15:8], rx_byte};
    assign count_inc  = count_reg + CNT_W'(1);
    assign count_ext  = 16'(count_reg);
    assign sum_add    = sum_reg + rx_byte;

    always_comb begin
        phase_next  = phase_reg;
        length_next = length_reg;
        count_next  = count_reg;
        sum_next    = sum_reg;
        res         = '{status: ST_PARSING, kind: KIND_NONE, payload: 8'd0,
                        data_index: 8'd0, last_data: 1'b0, frame_length: 16'd0};
        case (phase_reg)
            PH_HUNT: begin
                if (rx_byte == START_BYTE) begin
                    phase_next = PH_LEN_HI;
                end else begin
                    res.status = ST_IDLE;
                end
            end
            PH_LEN_HI: begin
                length_next = {rx_byte, 8'h00};
                phase_next  = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                length_next      = length_new;
                res.frame_length = length_new;
                // Reject frames with no data byte or more data than the limit.
                if (length_new < MIN_LENGTH || {1'b0, length_new} > MAX_LENGTH) begin
                    phase_next = PH_HUNT;
                    res.status = ST_FAIL;
                end else begin
                    phase_next = PH_TYPE;
                end
            end
            PH_TYPE: begin
                sum_next         = rx_byte;
                res.kind         = KIND_TYPE;
                res.payload      = rx_byte;
                res.frame_length = length_reg;
                phase_next       = PH_DATA;
            end
            PH_DATA: begin
                sum_next         = sum_add;
                res.kind         = KIND_DATA;
                res.payload      = rx_byte;
                res.data_index   = count_ext[7:0];
                res.frame_length = length_reg;
                if (16'(count_inc) >= (length_reg - 16'd1)) begin
                    res.last_data = 1'b1;
                    count_next    = '0;
                    phase_next    = PH_CHECK;
                end else begin
                    count_next = count_inc;
                end
            end
            PH_CHECK: begin
                res.frame_length = length_reg;
                phase_next       = PH_HUNT;
                res.status       = (sum_add == GOOD_SUM) ? ST_GOOD : ST_FAIL;
            end
            default: begin
                phase_next = PH_HUNT;
                res.status = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_HUNT;
            length_reg <= 16'd0;
            count_reg  <= '0;
            sum_reg    <= 8'd0;
        end else if (step) begin
            phase_reg  <= phase_next;
            length_reg <= length_next;
            count_reg  <= count_next;
            sum_reg    <= sum_next;
        end
    end

    `AFBP_ASSERT_NEXT(a_type_then_data, aclk, aresetn, step && phase_reg == PH_TYPE,
        phase_reg == PH_DATA, "type byte not followed by data phase")
    `AFBP_ASSERT_IMPLY(a_count_idle, aclk, aresetn, phase_reg != PH_DATA,
        count_reg == '0, "data counter not cleared outside the data phase")
    `AFBP_ASSERT_NEXT(a_good_then_hunt, aclk, aresetn, step && res.status == ST_GOOD,
        phase_reg == PH_HUNT, "parser did not return to hunting after a good frame")

endmodule

// ===== rtl/api_frame_byte_parser.sv =====
// API frame byte parser: one received byte in, one parse result out per transaction.
// The input transaction is accepted on the slave channel when s_tvalid and s_tready
// are both high; the byte sits in an input register and then goes through the frame
// state machine in afbp_core, whose result lands in the output register.
// The result reaches the output register, which drives m_tvalid, after its byte has
// passed the input register and afbp_core; the receiver takes it while m_tready is high.
// Throughput is one byte per cycle while the receiver keeps m_tready high; the limit
// is the single state update of afbp_core per cycle.
// The input and output registers are separate stages, so a new byte is taken into
// the input register while a finished result still waits on the master channel.
// When the receiver stalls, the result holds and at most one more byte is absorbed;
// then s_tready drops until the receiver takes the result.
// Reset (aresetn low at a clock edge) empties both stages and returns the parser
// to hunting for the start delimiter with a cleared length, counter and checksum.
// Depends on afbp_pkg, afbp_core and api_frame_byte_parser_defines.svh.
`include "api_frame_byte_parser_defines.svh"
module api_frame_byte_parser #(
    parameter int MAX_DATA = afbp_pkg::MAX_DATA_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Slave channel: tdata = rx_byte[7:0].
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,
    // Master channel: tdata = status[1:0], payload_byte[9:2], data_index[17:10],
    // frame_length[33:18], zeros[39:34].
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,
    // tuser = byte_kind[1:0].
    output logic [1:0]  m_tuser,
    // tlast = last_data.
    output logic        m_tlast
);
    import afbp_pkg::*;

    logic        in_valid_reg, in_valid_next;
    logic [7:0]  in_byte_reg;
    logic        out_valid_reg, out_valid_next;
    result_t     out_reg;
    result_t     core_res;
    logic        s_fire;
    logic        core_fire;

    // The core takes the registered byte when the output stage is free or draining.
    assign core_fire = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || core_fire;
    assign s_fire    = s_tvalid && s_tready;

    assign in_valid_next  = s_fire ? 1'b1 : (core_fire ? 1'b0 : in_valid_reg);
    assign out_valid_next = core_fire ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);

    afbp_core #(
        .MAX_DATA (MAX_DATA)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (core_fire),
        .rx_byte (in_byte_reg),
        .res     (core_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_byte_reg <= s_tdata;
        end
        if (core_fire) begin
            out_reg <= core_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_reg.frame_length, out_reg.data_index, out_reg.payload,
                       out_reg.status};
    assign m_tuser  = out_reg.kind;
    assign m_tlast  = out_reg.last_data;

    `AFBP_ASSERT_IMPLY(a_last_is_data, aclk, aresetn, m_tvalid && m_tlast,
        m_tuser == KIND_DATA, "last marker on a result that is not a data byte")
    `AFBP_ASSERT_NEXT(a_step_gives_result, aclk, aresetn, core_fire,
        m_tvalid, "core step did not produce a result")
    `AFBP_ASSERT_NEXT(a_hold_stalled, aclk, aresetn, m_tvalid && !m_tready,
        m_tvalid, "result dropped while the receiver stalled")

endmodule

// ===== tb/api_frame_byte_parser_tb.sv =====
// Self-checking testbench for api_frame_byte_parser: byte streams in, parse results out.
// Depends on afbp_pkg and the api_frame_byte_parser RTL; it needs no other files.
// Expectations come from a frame predictor inside this file, checked result by result.
module api_frame_byte_parser_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import afbp_pkg::*;

    localparam int DATA_MAX       = MAX_DATA_DEFAULT;
    localparam int RANDOM_BYTES   = 1500;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int MAX_REPORTS    = 10;
    localparam int DRAIN_CYCLES   = 10;

    // Parser position as this bench tracks it, one step per accepted byte.
    typedef enum logic [2:0] {
        P_HUNT,
        P_LEN_HI,
        P_LEN_LO,
        P_TYPE,
        P_DATA,
        P_CHECK
    } parse_phase_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;    // rx_byte[7:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;    // status[1:0], payload[9:2], index[17:10], length[33:18]
    logic [1:0]  m_tuser;    // byte_kind[1:0]
    logic        m_tlast;    // last_data

    // Predictor state: phase, length field, data bytes taken and the type/data sum.
    parse_phase_t ph;
    logic [15:0]  cur_len;
    int           data_seen;
    logic [7:0]   type_data_sum;

    // Expected parse results, oldest first.
    result_t parse_expect_q[$];

    // Run bookkeeping.
    int bytes_sent;
    int results_checked;
    int mismatches;
    int unexpected_results;
    int frames_good;
    int frames_bad_sum;
    int frames_bad_len;
    int idle_cycles;

    // Idling controls shared by the sender task and the receiver process.
    bit src_idle_en;
    bit sink_idle_en;
    int hold_req;
    int hold_left;
    int sink_gap;

    api_frame_byte_parser #(
        .MAX_DATA (DATA_MAX)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // Idle length used on both sides: mostly none or short, now and then long.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end else if (r < 99) begin
            return $urandom_range(4, 12);
        end else begin
            return $urandom_range(20, 50);
        end
    endfunction

    // Advances the predictor by one received byte and returns the result it should cause.
    function automatic result_t next_result(input logic [7:0] b);
        result_t    r;
        logic [7:0] total;
        r = '0;
        r.status = ST_PARSING;
        case (ph)
            P_HUNT: begin
                if (b == START_BYTE) begin
                    ph = P_LEN_HI;
                end else begin
                    r.status = ST_IDLE;
                end
            end
            P_LEN_HI: begin
                // The length is not known yet, so frame_length still reads zero.
                cur_len = {b, 8'h00};
                ph = P_LEN_LO;
            end
            P_LEN_LO: begin
                cur_len[7:0] = b;
                r.frame_length = cur_len;
                if (cur_len < MIN_LENGTH || int'(cur_len) - 1 > DATA_MAX) begin
                    r.status = ST_FAIL;
                    ph = P_HUNT;
                    frames_bad_len++;
                end else begin
                    ph = P_TYPE;
                end
            end
            P_TYPE: begin
                type_data_sum = b;
                r.kind = KIND_TYPE;
                r.payload = b;
                r.frame_length = cur_len;
                ph = P_DATA;
            end
            P_DATA: begin
                type_data_sum = type_data_sum + b;
                r.kind = KIND_DATA;
                r.payload = b;
                r.data_index = data_seen[7:0];
                r.frame_length = cur_len;
                data_seen++;
                if (data_seen >= int'(cur_len) - 1) begin
                    r.last_data = 1'b1;
                    data_seen = 0;
                    ph = P_CHECK;
                end
            end
            P_CHECK: begin
                total = type_data_sum + b;
                r.frame_length = cur_len;
                ph = P_HUNT;
                if (total == GOOD_SUM) begin
                    r.status = ST_GOOD;
                    frames_good++;
                end else begin
                    r.status = ST_FAIL;
                    frames_bad_sum++;
                end
            end
            default: begin
                ph = P_HUNT;
                r.status = ST_IDLE;
            end
        endcase
        return r;
    endfunction

    // Offers one byte on the slave channel, starting and ending at a falling edge.
    // The valid line is only lowered when an idle gap is taken, so back-to-back
    // transactions keep it high without a glitch.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = src_idle_en ? idle_len() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do begin
            @(posedge aclk);
        end while (!s_tready);
        parse_expect_q.push_back(next_result(b));
        bytes_sent++;
        @(negedge aclk);
    endtask

    // Sends a frame with the given length field. A fill below zero means random type
    // and data bytes; otherwise every type and data byte is the fill value. A rejected
    // length stops after the length bytes, as the parser goes back to hunting.
    task automatic send_frame(input int len, input bit bad_sum, input int fill);
        logic [15:0] len_field;
        logic [7:0]  b;
        logic [7:0]  sum;
        logic [7:0]  cks;
        len_field = len[15:0];
        send_byte(START_BYTE);
        send_byte(len_field[15:8]);
        send_byte(len_field[7:0]);
        if (len_field < MIN_LENGTH || int'(len_field) - 1 > DATA_MAX) begin
            return;
        end
        sum = 8'h00;
        for (int i = 0; i < int'(len_field); i++) begin
            b = (fill < 0) ? 8'($urandom_range(0, 255)) : fill[7:0];
            sum = sum + b;
            send_byte(b);
        end
        cks = GOOD_SUM - sum;
        if (bad_sum) begin
            cks = cks ^ 8'($urandom_range(1, 255));
        end
        send_byte(cks);
    endtask

    // Random length field that the parser accepts; mostly short frames.
    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 94) begin
            return $urandom_range(2, 12);
        end else if (r < 98) begin
            return $urandom_range(13, 64);
        end else begin
            return $urandom_range(200, DATA_MAX + 1);
        end
    endfunction

    // Receiver: random stalls, plus a long hold-off whenever a test asks for one.
    always @(negedge aclk) begin
        if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (sink_idle_en) begin
            sink_gap = idle_len();
            if (sink_gap > 0) begin
                hold_left = sink_gap - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Result checker: every accepted master transaction is compared with the
    // oldest expectation, field by field.
    always @(posedge aclk) begin
        result_t got;
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.status       = status_t'(m_tdata[1:0]);
            got.kind         = kind_t'(m_tuser);
            got.payload      = m_tdata[9:2];
            got.data_index   = m_tdata[17:10];
            got.last_data    = m_tlast;
            got.frame_length = m_tdata[33:18];
            if (parse_expect_q.size() == 0) begin
                unexpected_results++;
                if (mismatches + unexpected_results <= MAX_REPORTS) begin
                    $display("[%0t] result with nothing expected: status %0d kind %0d",
                             $realtime, got.status, got.kind);
                end
            end else begin
                want = parse_expect_q.pop_front();
                results_checked++;
                if (got !== want) begin
                    mismatches++;
                    if (mismatches + unexpected_results <= MAX_REPORTS) begin
                        $display("[%0t] result %0d mismatch:", $realtime, results_checked);
                        $display({"  expected status %0d kind %0d payload %02h",
                                  " idx %0d last %0b len %0d"},
                                 want.status, want.kind, want.payload, want.data_index,
                                 want.last_data, want.frame_length);
                        $display({"  actual   status %0d kind %0d payload %02h",
                                  " idx %0d last %0b len %0d"},
                                 got.status, got.kind, got.payload, got.data_index,
                                 got.last_data, got.frame_length);
                    end
                end
            end
        end
    end

    // Watchdog: too many cycles without any transaction on either channel ends the run.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
                         idle_cycles, parse_expect_q.size());
                $display("api_frame_byte_parser_tb: done, errors");
                $finish;
            end
        end
    end

    // Bytes outside a frame: the parser reports idle and ignores them.
    task automatic test_hunt_noise();
        send_byte(8'h00);
        send_byte(8'hFF);
    endtask

    // Length fields of zero and one are below the minimum and fail at once.
    task automatic test_short_length();
        send_frame(0, 1'b0, -1);
        send_frame(1, 1'b0, -1);
    endtask

    // One data byte past the maximum is rejected on the length low byte.
    task automatic test_long_length();
        send_frame(DATA_MAX + 2, 1'b0, -1);
    endtask

    // Shortest legal frame: a type byte and one data byte, all ones, good checksum.
    task automatic test_min_frame();
        send_frame(2, 1'b0, 8'hFF);
    endtask

    // Shortest frame with all-zero content and a corrupted checksum.
    task automatic test_bad_checksum();
        send_frame(2, 1'b1, 8'h00);
    endtask

    // A start delimiter value inside a frame is ordinary content.
    task automatic test_delim_in_frame();
        send_frame(3, 1'b0, START_BYTE);
    endtask

    // Largest accepted frame (data index spans its full range), then length FFFF.
    task automatic test_max_frame();
        send_frame(DATA_MAX + 1, 1'b0, -1);
        send_frame(16'hFFFF, 1'b0, -1);
    endtask

    // The receiver holds off for a long stretch while the sender keeps offering
    // bytes back to back, so both stages fill and s_tready drops.
    task automatic test_backpressure();
        src_idle_en = 1'b0;
        hold_req = 300;
        repeat (4) send_frame(6, 1'b0, -1);
        src_idle_en = 1'b1;
    endtask

    // Mostly well-formed frames with random content and lengths, mixed with bad
    // checksums, rejected lengths and bursts of noise. Idling on each side is
    // switched off now and then to get stretches of full throughput.
    task automatic test_random_stream();
        int target;
        int r;
        target = bytes_sent + RANDOM_BYTES;
        while (bytes_sent < target) begin
            if ($urandom_range(0, 29) == 0) begin
                src_idle_en  = $urandom_range(0, 2) != 0;
                sink_idle_en = $urandom_range(0, 2) != 0;
            end
            r = $urandom_range(0, 99);
            if (r < 65) begin
                send_frame(pick_len(), 1'b0, -1);
            end else if (r < 77) begin
                send_frame(pick_len(), 1'b1, -1);
            end else if (r < 85) begin
                if ($urandom_range(0, 1) == 0) begin
                    send_frame($urandom_range(0, 1), 1'b0, -1);
                end else begin
                    send_frame($urandom_range(DATA_MAX + 2, 65535), 1'b0, -1);
                end
            end else begin
                repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
            end
        end
        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;
    endtask

    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = 8'h00;
        m_tready = 1'b0;

        ph            = P_HUNT;
        cur_len       = 16'h0000;
        data_seen     = 0;
        type_data_sum = 8'h00;

        bytes_sent         = 0;
        results_checked    = 0;
        mismatches         = 0;
        unexpected_results = 0;
        frames_good        = 0;
        frames_bad_sum     = 0;
        frames_bad_len     = 0;
        idle_cycles        = 0;
        src_idle_en        = 1'b1;
        sink_idle_en       = 1'b1;
        hold_req           = 0;
        hold_left          = 0;

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_hunt_noise();
        test_short_length();
        test_long_length();
        test_min_frame();
        test_bad_checksum();
        test_delim_in_frame();
        test_max_frame();
        test_backpressure();
        test_random_stream();

        // All stimulus is in; stop offering and let the last results drain.
        s_tvalid <= 1'b0;
        while (parse_expect_q.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("covered %0d bytes, %0d results: %0d good frames, %0d bad checksums,",
                 bytes_sent, results_checked, frames_good, frames_bad_sum);
        $display("  %0d bad lengths; mismatches %0d, unexpected %0d, outstanding %0d",
                 frames_bad_len, mismatches, unexpected_results, parse_expect_q.size());
        if (mismatches == 0 && unexpected_results == 0 && parse_expect_q.size() == 0) begin
            $display("api_frame_byte_parser_tb: done, clean");
        end else begin
            $display("api_frame_byte_parser_tb: done, errors");
        end
        $finish;
    end

endmodule
